[rtl/bls_pkg.sv]
// Package for the bounded LIFO stack: codes, widths, state and cell control types.
`timescale 1ns / 1ps
`default_nettype none
package bls_pkg;

  // Word and field widths
  localparam int unsigned WordW  = 32;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned PosW   = 7;
  localparam int unsigned LimitW = 7;
  localparam int unsigned CountW = 7;
  localparam int unsigned ErrW   = 2;

  // Reset value of the capacity limit register
  localparam logic [LimitW-1:0] ResetLimit = 7'd5;

  // Operation codes
  localparam logic [ModeW-1:0] ModePush  = 3'd0;
  localparam logic [ModeW-1:0] ModePop   = 3'd1;
  localparam logic [ModeW-1:0] ModePeek  = 3'd2;
  localparam logic [ModeW-1:0] ModeRead  = 3'd3;
  localparam logic [ModeW-1:0] ModeWrite = 3'd4;

  // Data word returned with any error
  localparam logic [WordW-1:0] ErrWord = '1;

  // Result error codes
  typedef enum logic [ErrW-1:0] {
    ErrNone      = 2'd0,
    ErrOverflow  = 2'd1,
    ErrUnderflow = 2'd2
  } bls_err_e;

  // Controller states
  typedef enum logic {
    StIdle,
    StScan
  } bls_state_e;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
    logic wr;
  } bls_cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/bls_if.sv]
// Handshake interfaces for the request and result channels of the LIFO stack.
`timescale 1ns / 1ps
`default_nettype none
interface bls_req_if;
  logic                              valid;
  logic                              ready;
  logic        [bls_pkg::ModeW-1:0]  mode;
  logic signed [bls_pkg::WordW-1:0]  value;
  logic        [bls_pkg::PosW-1:0]   position;

  modport source (output valid, mode, value, position, input ready);
  modport sink   (input valid, mode, value, position, output ready);
endinterface

interface bls_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [bls_pkg::WordW-1:0]  data;
  logic        [bls_pkg::ErrW-1:0]   error_code;
  logic                              is_empty;
  logic                              is_full;
  logic        [bls_pkg::CountW-1:0] entry_count;

  modport source (output valid, data, error_code, is_empty, is_full, entry_count,
                  input ready);
  modport sink   (input valid, data, error_code, is_empty, is_full, entry_count,
                  output ready);
endinterface
`default_nettype wire

[rtl/bls_cell.sv]
// One stack cell: holds one entry, shifts on push and pop, forwards the read chain.
`timescale 1ns / 1ps
`default_nettype none
module bls_cell (
  input  wire logic                         clk_i,
  input  wire bls_pkg::bls_cell_ctrl_t      ctrl_i,
  input  wire logic                         wr_hit_i,
  input  wire logic                         scan_hit_i,
  input  wire logic [bls_pkg::WordW-1:0]    value_i,
  input  wire logic [bls_pkg::WordW-1:0]    above_i,
  input  wire logic [bls_pkg::WordW-1:0]    below_i,
  input  wire logic [bls_pkg::WordW-1:0]    ret_i,
  output logic      [bls_pkg::WordW-1:0]    entry_o,
  output logic      [bls_pkg::WordW-1:0]    ret_o
);

  logic [bls_pkg::WordW-1:0] entry_q, entry_d;
  logic [bls_pkg::WordW-1:0] ret_q, ret_d;

  // Entry update: push takes the word above, pop the word below, a write hit the new value
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      entry_d = above_i;
    end else if (ctrl_i.pop) begin
      entry_d = below_i;
    end else if (ctrl_i.wr && wr_hit_i) begin
      entry_d = value_i;
    end
  end

  // Read chain: the addressed cell injects its entry, others pass on from below
  assign ret_d = scan_hit_i ? entry_q : ret_i;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    ret_q   <= ret_d;
  end

  assign entry_o = entry_q;
  assign ret_o   = ret_q;

endmodule
`default_nettype wire

[rtl/bounded_lifo_stack_core.sv]
// Top level of the bounded LIFO stack: cell chain, count, limit register and controller.
`timescale 1ns / 1ps
`default_nettype none
// Bounded LIFO stack of 32-bit words held in a chain of DEPTH cells, top in cell 0.
// Requests arrive on in_if (mode, value, position); every request gives exactly one
// result beat on out_if (data, error_code, is_empty, is_full, entry_count).
// The capacity limit is written through cfg_we_i / cfg_wdata_i; the user must write it only
// while idle, which the block does not enforce; it is capped at DEPTH.
// Push, pop, peek, overwrite and every error case finish in the accept cycle: the
// result is registered in the output register at the end of that cycle, and a new
// request can be taken every cycle while the receiver takes results.
// A read at position p walks the return chain one cell per cycle from cell p-1 to
// cell 0; the result is loaded into the output register once the scan count reaches
// zero, and no new request is taken until the controller is back in idle.
// The output register decouples the sides: a request is accepted while a result
// still waits provided that result is taken in the same cycle; while the receiver
// stalls the result holds and no further request is accepted.
// Reset empties the stack, loads the limit with 5 and drops any pending result;
// cell contents are not cleared.
module bounded_lifo_stack_core #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bls_pkg::LimitW-1:0]    cfg_wdata_i,
  bls_req_if.sink                            in_if,
  bls_rsp_if.source                          out_if
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > bls_pkg::PosW) ? CntW : bls_pkg::PosW;

  // Limit register
  logic [bls_pkg::LimitW-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bls_pkg::ResetLimit;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Control state
  bls_pkg::bls_state_e       state_q, state_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [bls_pkg::PosW-1:0]  scan_cnt_q, scan_cnt_d;
  logic [bls_pkg::PosW-1:0]  pos_q;
  logic                      out_valid_q;

  // Output payload registers
  logic [bls_pkg::WordW-1:0]  out_data_q, out_data_d;
  bls_pkg::bls_err_e          out_err_q, out_err_d;
  logic                       out_empty_q, out_full_q;
  logic [bls_pkg::CountW-1:0] out_count_q;

  logic [bls_pkg::WordW-1:0] entry [DEPTH];
  logic [bls_pkg::WordW-1:0] ret   [DEPTH];

  logic acc, in_ready, scan_done, load_out, start_scan;
  logic [CmpW-1:0] cnt_w, lim_w, pos_w, cnt_next_w;
  logic push_ok, nonempty, pos_ok;
  bls_pkg::bls_cell_ctrl_t cell_ctrl;

  assign acc   = in_if.valid && in_ready;
  assign cnt_w = CmpW'(count_q);
  assign pos_w = CmpW'(in_if.position);
  assign lim_w = (CmpW'(cap_q) > CmpW'(DEPTH)) ? CmpW'(DEPTH) : CmpW'(cap_q);

  assign push_ok  = cnt_w < lim_w;
  assign nonempty = count_q != '0;
  assign pos_ok   = (pos_w != '0) && (pos_w <= cnt_w);

  // Request decode: cell control, next count and immediate result
  always_comb begin
    cell_ctrl  = '0;
    count_d    = count_q;
    start_scan = 1'b0;
    out_data_d = bls_pkg::ErrWord;
    out_err_d  = bls_pkg::ErrUnderflow;
    if (state_q == bls_pkg::StScan) begin
      out_data_d = ret[0];
      out_err_d  = bls_pkg::ErrNone;
    end else begin
      case (in_if.mode)
        bls_pkg::ModePush: begin
          if (push_ok) begin
            cell_ctrl.push = acc;
            count_d        = acc ? count_q + CntW'(1) : count_q;
            out_data_d     = '0;
            out_err_d      = bls_pkg::ErrNone;
          end else begin
            out_err_d = bls_pkg::ErrOverflow;
          end
        end
        bls_pkg::ModePop: begin
          if (nonempty) begin
            cell_ctrl.pop = acc;
            count_d       = acc ? count_q - CntW'(1) : count_q;
            out_data_d    = entry[0];
            out_err_d     = bls_pkg::ErrNone;
          end
        end
        bls_pkg::ModePeek: begin
          if (nonempty) begin
            out_data_d = entry[0];
            out_err_d  = bls_pkg::ErrNone;
          end
        end
        bls_pkg::ModeRead: begin
          start_scan = pos_ok;
        end
        bls_pkg::ModeWrite: begin
          if (pos_ok) begin
            cell_ctrl.wr = acc;
            out_data_d   = in_if.value;
            out_err_d    = bls_pkg::ErrNone;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt_next_w = CmpW'(count_d);
  assign scan_done  = scan_cnt_q == '0;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bls_pkg::StIdle: begin
        if (acc && start_scan) begin
          state_d = bls_pkg::StScan;
        end
      end
      bls_pkg::StScan: begin
        if (scan_done) begin
          state_d = bls_pkg::StIdle;
        end
      end
      default: state_d = bls_pkg::StIdle;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready   = 1'b0;
    load_out   = 1'b0;
    scan_cnt_d = scan_cnt_q;
    case (state_q)
      bls_pkg::StIdle: begin
        in_ready = !out_valid_q || out_if.ready;
        load_out = acc && !start_scan;
        if (acc && start_scan) begin
          scan_cnt_d = in_if.position;
        end
      end
      bls_pkg::StScan: begin
        load_out = scan_done;
        if (!scan_done) begin
          scan_cnt_d = scan_cnt_q - bls_pkg::PosW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bls_pkg::StIdle;
      count_q     <= '0;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      scan_cnt_q <= scan_cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Position held for the read chain, result payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      pos_q <= in_if.position;
    end
    if (load_out) begin
      out_data_q  <= out_data_d;
      out_err_q   <= out_err_d;
      out_empty_q <= count_d == '0;
      out_full_q  <= cnt_next_w >= lim_w;
      out_count_q <= bls_pkg::CountW'(count_d);
    end
  end

  // Chain of cells, cell 0 is the top of the stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      wr_hit, scan_hit;
    logic [bls_pkg::WordW-1:0] above, below, ret_in;

    assign wr_hit   = pos_w == CmpW'(i + 1);
    assign scan_hit = (state_q == bls_pkg::StScan) && (CmpW'(pos_q) == CmpW'(i + 1));

    if (i == 0) begin : g_top
      assign above = in_if.value;
    end else begin : g_mid
      assign above = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign below  = entry[i];
      assign ret_in = '0;
    end else begin : g_up
      assign below  = entry[i+1];
      assign ret_in = ret[i+1];
    end

    bls_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .wr_hit_i   (wr_hit),
      .scan_hit_i (scan_hit),
      .value_i    (in_if.value),
      .above_i    (above),
      .below_i    (below),
      .ret_i      (ret_in),
      .entry_o    (entry[i]),
      .ret_o      (ret[i])
    );
  end

  assign in_if.ready        = in_ready;
  assign out_if.valid       = out_valid_q;
  assign out_if.data        = out_data_q;
  assign out_if.error_code  = out_err_q;
  assign out_if.is_empty    = out_empty_q;
  assign out_if.is_full     = out_full_q;
  assign out_if.entry_count = out_count_q;

endmodule
`default_nettype wire

[rtl/bls_checker.sv]
// Port-level checker for the LIFO stack result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bls_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [bls_pkg::WordW-1:0]    out_data_i,
  input wire logic [bls_pkg::ErrW-1:0]     out_err_i,
  input wire logic                         out_empty_i,
  input wire logic                         out_full_i,
  input wire logic [bls_pkg::CountW-1:0]   out_count_i
);

  // A stalled result beat holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i)
      && $stable(out_count_i))
    else $error("result beat changed while stalled");

  // Any error returns the all-ones word
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_err_i != bls_pkg::ErrNone) |-> out_data_i == bls_pkg::ErrWord)
    else $error("error result without all-ones data");

  // Overflow is only reported on a full stack
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_err_i == bls_pkg::ErrOverflow) |-> out_full_i)
    else $error("overflow reported while not full");

  // Empty flag agrees with the count
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_empty_i == (out_count_i == '0))
    else $error("empty flag disagrees with entry count");

  // Only the three defined error codes appear
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_err_i == bls_pkg::ErrNone) || (out_err_i == bls_pkg::ErrOverflow)
      || (out_err_i == bls_pkg::ErrUnderflow))
    else $error("undefined error code");

endmodule

bind bounded_lifo_stack_core bls_checker u_bls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data),
  .out_err_i   (out_if.error_code),
  .out_empty_i (out_if.is_empty),
  .out_full_i  (out_if.is_full),
  .out_count_i (out_if.entry_count)
);
`default_nettype wire

[tb/stack_result_checker.sv]
// Result checker for the bounded LIFO stack: watches both channels and the limit port.
`timescale 1ns / 1ps
module stack_result_checker
  import bls_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  bls_req_if                req_if,
  bls_rsp_if                rsp_if,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  // One expected result beat
  typedef struct packed {
    logic [WordW-1:0]  data;
    bls_err_e          err;
    logic              empty;
    logic              full;
    logic [CountW-1:0] count;
  } stack_result_t;

  // Shadow of the stack contents, fill level and limit register
  logic [WordW-1:0]  stack_words [DEPTH];
  int unsigned       fill_level;
  logic [LimitW-1:0] limit_reg;

  stack_result_t     answers_q [$];
  stack_result_t     want;
  int unsigned       beat_no;

  task automatic report(input string what, input logic [WordW-1:0] got,
                        input logic [WordW-1:0] exp_val);
    $display("%0t result %0d: %s got %0h, want %0h", $time, beat_no, what, got, exp_val);
    fail_count_o++;
  endtask

  // Works out the result of one request and moves the shadow state on
  function automatic stack_result_t stack_answer(input logic [ModeW-1:0] mode,
                                                 input logic [WordW-1:0] value,
                                                 input logic [PosW-1:0]  pos);
    int unsigned   lim;
    int unsigned   slot;
    stack_result_t r;
    lim    = (limit_reg > DEPTH) ? DEPTH : limit_reg;
    r.data = ErrWord;
    r.err  = ErrUnderflow;
    case (mode)
      ModePush: begin
        if (fill_level >= lim) begin
          r.err = ErrOverflow;
        end else begin
          stack_words[fill_level] = value;
          fill_level++;
          r.data = '0;
          r.err  = ErrNone;
        end
      end
      ModePop: begin
        if (fill_level != 0) begin
          fill_level--;
          r.data = stack_words[fill_level];
          r.err  = ErrNone;
        end
      end
      ModePeek: begin
        if (fill_level != 0) begin
          r.data = stack_words[fill_level - 1];
          r.err  = ErrNone;
        end
      end
      ModeRead, ModeWrite: begin
        // position 1 is the top; 0 and anything past the bottom are errors
        if (pos >= 1 && pos <= fill_level) begin
          slot = fill_level - pos;
          if (mode == ModeWrite) stack_words[slot] = value;
          r.data = stack_words[slot];
          r.err  = ErrNone;
        end
      end
      default: ;  // unknown modes only report an error
    endcase
    r.empty = (fill_level == 0);
    r.full  = (fill_level >= lim);
    r.count = fill_level[CountW-1:0];
    return r;
  endfunction

  // Sample both channels at the edge; results are checked before new requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_level = 0;
      limit_reg  = ResetLimit;
      answers_q.delete();
      pending_o  = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        beat_no++;
        if (answers_q.size() == 0) begin
          report("result with nothing pending, data", rsp_if.data, ErrWord);
        end else begin
          want = answers_q.pop_front();
          if (rsp_if.data !== want.data) report("data", rsp_if.data, want.data);
          if (rsp_if.error_code !== want.err)
            report("error_code", rsp_if.error_code, want.err);
          if (rsp_if.is_empty !== want.empty) report("is_empty", rsp_if.is_empty, want.empty);
          if (rsp_if.is_full !== want.full) report("is_full", rsp_if.is_full, want.full);
          if (rsp_if.entry_count !== want.count)
            report("entry_count", rsp_if.entry_count, want.count);
        end
      end
      if (req_if.valid && req_if.ready)
        answers_q.push_back(stack_answer(req_if.mode, req_if.value, req_if.position));
      if (cfg_we_i) limit_reg = cfg_wdata_i;
      pending_o = answers_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
// Testbench top for the bounded LIFO stack: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import bls_pkg::*;

  localparam int unsigned Depth      = 64;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 50;

  logic              clk   = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we;
  logic [LimitW-1:0] cfg_wdata;
  bit                calm;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       cycle_count;

  bls_req_if req_bus ();
  bls_rsp_if rsp_bus ();

  bounded_lifo_stack_core #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (req_bus),
    .out_if     (rsp_bus)
  );

  stack_result_checker #(
    .DEPTH(Depth)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_if      (req_bus),
    .rsp_if      (rsp_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stall before taking each beat
  initial begin
    int unsigned stall;
    rsp_bus.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  // One request beat; valid stays high after acceptance unless a gap follows
  task automatic send_req(input logic [ModeW-1:0] mode, input logic [WordW-1:0] value,
                          input logic [PosW-1:0] pos);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_bus.valid    <= 1'b0;
      req_bus.mode     <= $urandom_range(0, 7);
      req_bus.value    <= $urandom;
      req_bus.position <= $urandom_range(0, 127);
      repeat (gap) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.mode     <= mode;
    req_bus.value    <= value;
    req_bus.position <= pos;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // Hold off until every expected result has come back
  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LimitW-1:0] lim);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random request; filling phases lean on push, the others on pop
  task automatic random_req(input bit filling);
    int unsigned      pick;
    int unsigned      sel;
    logic [ModeW-1:0] mode;
    logic [WordW-1:0] value;
    logic [PosW-1:0]  pos;
    pick = $urandom_range(0, 99);
    if (pick < (filling ? 45 : 20))      mode = ModePush;
    else if (pick < 55)                  mode = ModePop;
    else if (pick < 63)                  mode = ModePeek;
    else if (pick < 80)                  mode = ModeRead;
    else if (pick < 96)                  mode = ModeWrite;
    else                                 mode = $urandom_range(5, 7);
    // occasional extreme words
    sel = $urandom_range(0, 63);
    case (sel)
      0:       value = '1;
      1:       value = 32'h8000_0000;
      2:       value = 32'h7fff_ffff;
      3:       value = '0;
      default: value = $urandom;
    endcase
    // positions mostly near the top, since deep reads walk the chain
    sel = $urandom_range(0, 19);
    case (sel)
      0:       pos = '0;
      1:       pos = $urandom_range(65, 127);
      2, 3:    pos = $urandom_range(1, 64);
      default: pos = $urandom_range(1, 8);
    endcase
    send_req(mode, value, pos);
  endtask

  initial begin
    logic [LimitW-1:0] phase_limit [8];
    req_bus.valid    = 1'b0;
    req_bus.mode     = ModePush;
    req_bus.value    = '0;
    req_bus.position = '0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    calm             = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty stack at the reset limit
    send_req(ModePop,   32'h1234_5678, 7'd1);
    send_req(ModePeek,  '0,            7'd0);
    send_req(ModeRead,  '0,            7'd1);
    send_req(ModeWrite, 32'hdead_beef, 7'd1);
    // Fill to the limit of five with extreme words, then overflow
    send_req(ModePush,  32'h7fff_ffff, 7'd0);
    send_req(ModePush,  32'h8000_0000, 7'd0);
    send_req(ModePush,  '1,            7'd0);
    send_req(ModePush,  '0,            7'd0);
    send_req(ModePush,  32'd1,         7'd0);
    send_req(ModePush,  32'h0bad_cafe, 7'd0);
    send_req(ModePeek,  '0,            7'd0);
    // Positions: zero, bottom, one past the bottom, all ones
    send_req(ModeRead,  '0,            7'd0);
    send_req(ModeRead,  '0,            7'd5);
    send_req(ModeRead,  '0,            7'd6);
    send_req(ModeRead,  '0,            7'h7f);
    send_req(ModeWrite, 32'h5555_5555, 7'd3);
    send_req(ModeWrite, 32'haaaa_aaaa, 7'd6);
    // Unknown modes
    send_req(3'd5,      '0,            7'd1);
    send_req(3'd6,      '0,            7'd1);
    send_req(3'd7,      '0,            7'd1);
    send_req(ModePop,   '0,            7'd0);
    // Zero limit: a push overflows and the full flag stays set
    set_limit(7'd0);
    send_req(ModePush,  32'h0000_0042, 7'd0);
    send_req(ModePeek,  '0,            7'd0);
    // Limit lowered below the current count
    set_limit(7'd2);
    send_req(ModePush,  32'h0000_0043, 7'd0);

    // Random phases across several limit settings, beyond DEPTH among them
    phase_limit[0] = 7'd64;
    phase_limit[1] = 7'd1;
    phase_limit[2] = 7'd127;
    phase_limit[3] = 7'd12;
    phase_limit[4] = $urandom_range(1, 64);
    phase_limit[5] = 7'd2;
    phase_limit[6] = 7'd64;
    phase_limit[7] = $urandom_range(0, 127);
    for (int ph = 0; ph < 8; ph++) begin
      set_limit(phase_limit[ph]);
      for (int i = 0; i < PhaseItems; i++) begin
        calm = ((i / 12) % 4 == 3);
        random_req(ph % 2 == 0 || phase_limit[ph] >= 64);
      end
      calm = 1'b0;
    end

    drain();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
